@@ rtl/core/fmd_pkg.sv @@
`timescale 1ns / 1ps

package fmd_pkg;

    // Receive modes
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_DRAW = 2'd1,
        MODE_MOVE = 2'd2,
        MODE_WORD = 2'd3
    } rx_mode_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_POS    = 3'd0,
        KIND_WORD   = 3'd1,
        KIND_WON    = 3'd2,
        KIND_BUTTON = 3'd3,
        KIND_DROP   = 3'd4
    } msg_kind_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MARKER     = 3'd0,
        CFG_DRAW       = 3'd1,
        CFG_MOVE       = 3'd2,
        CFG_WORD       = 3'd3,
        CFG_WON        = 3'd4,
        CFG_FIRST_BTN  = 3'd5,
        CFG_BTN_COUNT  = 3'd6,
        CFG_DRAWER     = 3'd7
    } cfg_index_t;

    localparam int unsigned COORD_LEN   = 4;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned OUT_DATA_W  = 48;

    // Coordinate byte count when full and after an overrun
    localparam logic [COUNT_W-1:0] COUNT_FULL    = 3'(COORD_LEN);
    localparam logic [COUNT_W-1:0] COUNT_OVERRUN = 3'(COORD_LEN + 1);

    // Register values after reset
    localparam logic [7:0] RST_MARKER    = 8'd255;
    localparam logic [7:0] RST_DRAW      = 8'd1;
    localparam logic [7:0] RST_MOVE      = 8'd2;
    localparam logic [7:0] RST_WORD      = 8'd3;
    localparam logic [7:0] RST_WON       = 8'd4;
    localparam logic [7:0] RST_FIRST_BTN = 8'd65;
    localparam logic [7:0] RST_BTN_COUNT = 8'd0;
    localparam logic       RST_DRAWER    = 1'b1;

endpackage

@@ rtl/core/framed_message_decoder_unit.sv @@
`timescale 1ns / 1ps

// Framed message decoder.
// s_axis carries received bytes, one per transaction. m_axis carries decoded
// messages: positions, word indexes, won-round events, button presses and
// dropped-frame reports. Bytes that cause no message are consumed silently.
// The cfg channel writes the eight code registers; it is always ready and
// should only be used while no message is outstanding.
// A message is registered in the output register, or in the skid register
// while the receiver stalls, on the transaction of the byte that completes
// it. Throughput: one byte per cycle while s_axis_tready is high; the byte
// is decoded against the frame state in a single pass.
// When the receiver stalls, one further message is held in a skid register
// and s_axis_tready drops only while that skid register is occupied, so
// bytes keep flowing unless two messages are waiting.
// Reset (aresetn low, synchronous) returns the codes to their defaults,
// the decoder to idle with an empty coordinate count, and empties the
// output and skid registers.
module framed_message_decoder_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Received bytes
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
    // Decoded messages
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [2:0]                       m_axis_tuser,  // [2:0] msg_kind
    // [15:0] pos_x, [31:16] pos_y, [32] pen_down, [40:33] value_byte, rest 0
    output logic [fmd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [7:0]                       cfg_data
);

    import fmd_pkg::*;

    // Configuration registers
    logic [7:0] marker_reg, draw_reg, move_reg, word_reg, won_reg;
    logic [7:0] first_btn_reg, btn_count_reg;
    logic       drawer_reg;

    // Decoder state
    rx_mode_t               mode_reg, mode_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [7:0]             coord_reg [COORD_LEN];
    logic                   coord_wr;

    // Result of the current byte
    logic                   res_emit;
    msg_kind_t              res_kind;
    logic [OUT_DATA_W-1:0]  res_data;
    logic [15:0]            res_x, res_y;
    logic                   res_pen;
    logic [7:0]             res_val;

    // Output and skid registers
    logic                   out_valid_reg, skid_valid_reg;
    msg_kind_t              out_kind_reg, skid_kind_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg, skid_data_reg;

    logic       in_accept;
    logic [7:0] rx_byte;
    logic       is_marker, is_draw, is_move, is_word, is_won, is_button;
    logic [8:0] btn_end;
    logic [7:0] btn_index;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign rx_byte       = s_axis_tdata;

    // Code matches
    assign is_marker = (rx_byte == marker_reg);
    assign is_draw   = (rx_byte == draw_reg);
    assign is_move   = (rx_byte == move_reg);
    assign is_word   = (rx_byte == word_reg);
    assign is_won    = (rx_byte == won_reg);
    assign btn_end   = {1'b0, first_btn_reg} + {1'b0, btn_count_reg};
    assign is_button = (rx_byte >= first_btn_reg) && ({1'b0, rx_byte} < btn_end);
    assign btn_index = rx_byte - first_btn_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg    <= RST_MARKER;
            draw_reg      <= RST_DRAW;
            move_reg      <= RST_MOVE;
            word_reg      <= RST_WORD;
            won_reg       <= RST_WON;
            first_btn_reg <= RST_FIRST_BTN;
            btn_count_reg <= RST_BTN_COUNT;
            drawer_reg    <= RST_DRAWER;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MARKER:    marker_reg    <= cfg_data;
                CFG_DRAW:      draw_reg      <= cfg_data;
                CFG_MOVE:      move_reg      <= cfg_data;
                CFG_WORD:      word_reg      <= cfg_data;
                CFG_WON:       won_reg       <= cfg_data;
                CFG_FIRST_BTN: first_btn_reg <= cfg_data;
                CFG_BTN_COUNT: btn_count_reg <= cfg_data;
                CFG_DRAWER:    drawer_reg    <= cfg_data[0];
                default:       drawer_reg    <= drawer_reg;
            endcase
        end
    end

    // Next state
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        coord_wr   = 1'b0;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (is_marker) begin
                    mode_next = MODE_IDLE;
                end else if (is_draw) begin
                    mode_next  = MODE_DRAW;
                    count_next = '0;
                end else if (is_move) begin
                    mode_next  = MODE_MOVE;
                    count_next = '0;
                end else if (is_word) begin
                    mode_next = MODE_WORD;
                end
            end
            MODE_DRAW, MODE_MOVE: begin
                if (!drawer_reg || is_marker) begin
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                end else if (count_reg < COUNT_FULL) begin
                    coord_wr   = 1'b1;
                    count_next = count_reg + 1'b1;
                end else begin
                    count_next = COUNT_OVERRUN;
                end
            end
            MODE_WORD: begin
                mode_next = MODE_IDLE;
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Result of the current byte
    always_comb begin
        res_emit = 1'b0;
        res_kind = KIND_POS;
        res_x    = '0;
        res_y    = '0;
        res_pen  = 1'b0;
        res_val  = '0;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (!is_marker && !is_draw && !is_move && !is_word) begin
                    if (is_won) begin
                        res_emit = 1'b1;
                        res_kind = KIND_WON;
                    end else if (is_button) begin
                        res_emit = 1'b1;
                        res_kind = KIND_BUTTON;
                        res_val  = btn_index;
                    end
                end
            end
            MODE_DRAW, MODE_MOVE: begin
                if (drawer_reg && is_marker) begin
                    res_emit = 1'b1;
                    if (count_reg == COUNT_FULL) begin
                        res_kind = KIND_POS;
                        res_x    = {coord_reg[1], coord_reg[0]};
                        res_y    = {coord_reg[3], coord_reg[2]};
                        res_pen  = (mode_reg == MODE_DRAW);
                    end else begin
                        res_kind = KIND_DROP;
                    end
                end
            end
            MODE_WORD: begin
                res_emit = 1'b1;
                if (is_marker) begin
                    res_kind = KIND_DROP;
                end else begin
                    res_kind = KIND_WORD;
                    res_val  = rx_byte;
                end
            end
            default: begin
                res_emit = 1'b0;
            end
        endcase
    end

    assign res_data = {7'b0, res_val, res_pen, res_y, res_x};

    // Decoder state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // Coordinate buffer
    always_ff @(posedge aclk) begin
        if (in_accept && coord_wr) begin
            coord_reg[count_reg[1:0]] <= rx_byte;
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_axis_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_accept && res_emit;
            end
        end else if (in_accept && res_emit) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_axis_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_kind_reg <= skid_kind_reg;
                out_data_reg <= skid_data_reg;
            end else begin
                out_kind_reg <= res_kind;
                out_data_reg <= res_data;
            end
        end else if (in_accept && res_emit) begin
            skid_kind_reg <= res_kind;
            skid_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    // Skid stage only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a message with the output empty");

    // Count never passes the overrun mark
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_OVERRUN)
        else $error("coordinate count out of range");

    // Outside a position frame the count rests at zero
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE || mode_reg == MODE_WORD) |-> count_reg == '0)
        else $error("coordinate count not cleared outside a position frame");

    // Non-position messages carry no coordinates
    a_no_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg != KIND_POS) |-> out_data_reg[32:0] == '0)
        else $error("coordinates set on a non-position message");

endmodule

@@ tb/sv/tb_framed_message_decoder_unit.sv @@
`timescale 1ns / 1ps

module tb_framed_message_decoder_unit;
    import fmd_pkg::*;

    // One decoded message as the decoder should report it
    typedef struct packed {
        msg_kind_t   kind;
        logic [15:0] x;
        logic [15:0] y;
        logic        pen;
        logic [7:0]  val;
    } msg_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [2:0]            m_axis_tuser;   // [2:0] msg_kind
    // [15:0] pos_x, [31:16] pos_y, [32] pen_down, [40:33] value_byte
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [7:0]            cfg_data;

    // Shadow copies of the code registers
    logic [7:0] code_marker, code_draw, code_move, code_word, code_won;
    logic [7:0] btn_first, btn_count;
    logic       drawer_on;

    // Shadow frame state
    rx_mode_t           frame_mode;
    logic [COUNT_W-1:0] coord_cnt;
    logic [7:0]         coord_buf [COORD_LEN];

    msg_t pending_msgs[$];
    int   mismatch_count;
    int   random_bytes;
    bit   quiet;

    framed_message_decoder_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Decode one accepted byte against the shadow state; queue any message
    task automatic decode_byte(input logic [7:0] b);
        msg_t m;
        bit   hit;
        m   = '0;
        hit = 1'b0;
        case (frame_mode)
            MODE_IDLE: begin
                // first match wins: marker, draw, move, word, won, button
                if (b == code_marker) begin
                end else if (b == code_draw) begin
                    frame_mode = MODE_DRAW;
                    coord_cnt  = '0;
                end else if (b == code_move) begin
                    frame_mode = MODE_MOVE;
                    coord_cnt  = '0;
                end else if (b == code_word) begin
                    frame_mode = MODE_WORD;
                end else if (b == code_won) begin
                    m.kind = KIND_WON;
                    hit    = 1'b1;
                end else if (int'(b) >= int'(btn_first) &&
                             int'(b) < int'(btn_first) + int'(btn_count)) begin
                    m.kind = KIND_BUTTON;
                    m.val  = b - btn_first;
                    hit    = 1'b1;
                end
            end
            MODE_DRAW, MODE_MOVE: begin
                if (!drawer_on) begin
                    // no drawer: frame abandoned without a message
                    frame_mode = MODE_IDLE;
                    coord_cnt  = '0;
                end else if (b == code_marker) begin
                    hit = 1'b1;
                    if (coord_cnt == COUNT_FULL) begin
                        m.kind = KIND_POS;
                        m.x    = {coord_buf[1], coord_buf[0]};
                        m.y    = {coord_buf[3], coord_buf[2]};
                        m.pen  = (frame_mode == MODE_DRAW);
                    end else begin
                        m.kind = KIND_DROP;
                    end
                    frame_mode = MODE_IDLE;
                    coord_cnt  = '0;
                end else if (coord_cnt < COUNT_FULL) begin
                    coord_buf[coord_cnt[1:0]] = b;
                    coord_cnt = coord_cnt + 1'b1;
                end else begin
                    coord_cnt = COUNT_OVERRUN;
                end
            end
            default: begin
                frame_mode = MODE_IDLE;
                hit        = 1'b1;
                if (b == code_marker) begin
                    m.kind = KIND_DROP;
                end else begin
                    m.kind = KIND_WORD;
                    m.val  = b;
                end
            end
        endcase
        if (hit)
            pending_msgs.push_back(m);
    endtask

    // Send one byte, with random gaps ahead of it
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 13) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        decode_byte(b);
        random_bytes++;
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait until every message has come out and the pipeline is empty
    task automatic settle();
        while (pending_msgs.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_MARKER:    code_marker = val;
            CFG_DRAW:      code_draw   = val;
            CFG_MOVE:      code_move   = val;
            CFG_WORD:      code_word   = val;
            CFG_WON:       code_won    = val;
            CFG_FIRST_BTN: btn_first   = val;
            CFG_BTN_COUNT: btn_count   = val;
            default:       drawer_on   = val[0];
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Random code value, biased towards the ends of the range
    function automatic logic [7:0] pick_code();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Random payload byte that cannot close a frame
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == code_marker);
        return b;
    endfunction

    task automatic randomize_codes(input bit clash_ok);
        logic [7:0] c [5];
        bit         dup;
        do begin
            foreach (c[i])
                c[i] = pick_code();
            dup = 1'b0;
            for (int i = 0; i < 5; i++)
                for (int j = i + 1; j < 5; j++)
                    if (c[i] == c[j])
                        dup = 1'b1;
        end while (dup && !clash_ok);
        write_reg(CFG_MARKER, c[0]);
        write_reg(CFG_DRAW, c[1]);
        write_reg(CFG_MOVE, c[2]);
        write_reg(CFG_WORD, c[3]);
        write_reg(CFG_WON, c[4]);
        write_reg(CFG_FIRST_BTN, pick_code());
        write_reg(CFG_BTN_COUNT, pick_code());
        write_reg(CFG_DRAWER, 8'($urandom_range(99) < 80));
    endtask

    // One message: mostly well formed, some broken frames and noise
    task automatic send_message();
        int n;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                send_byte($urandom_range(1) ? code_draw : code_move);
                repeat (COORD_LEN) send_byte(data_byte());
                send_byte(code_marker);
            end
            4: begin
                send_byte(code_word);
                send_byte(data_byte());
            end
            5: send_byte(code_won);
            6: begin
                if (btn_count != 0)
                    send_byte(8'(btn_first + $urandom_range(btn_count - 1)));
                else
                    send_byte(8'($urandom_range(255)));
            end
            7: begin
                // short frame or overrun
                send_byte($urandom_range(1) ? code_draw : code_move);
                n = $urandom_range(1) ? $urandom_range(3) : $urandom_range(7, 5);
                repeat (n) send_byte(data_byte());
                send_byte(code_marker);
            end
            8: begin
                send_byte(code_word);
                send_byte(code_marker);
            end
            default: begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    // Reset codes: every message kind but a button press, idle marker, early markers
    task automatic test_default_codes();
        send_byte(8'hFF);
        send_byte(8'h04);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h34);
        send_byte(8'h12);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h03);
        send_byte(8'hFE);
        send_byte(8'h03);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h07);
        send_byte(8'hFF);
        // no buttons enabled yet, so this one is ignored
        send_byte(8'h41);
    endtask

    // Marker moved to zero, all-ones payload overruns the buffer, top buttons
    task automatic test_overrun_and_buttons();
        write_reg(CFG_MARKER, 8'h00);
        write_reg(CFG_FIRST_BTN, 8'hF0);
        write_reg(CFG_BTN_COUNT, 8'h10);
        send_byte(8'h02);
        repeat (COORD_LEN + 1) send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hF5);
    endtask

    task automatic test_no_drawer();
        write_reg(CFG_DRAWER, 8'h00);
        send_byte(8'h01);
        send_byte(8'h09);
    endtask

    // Overlapping codes resolve in priority order
    task automatic test_code_collisions();
        write_reg(CFG_DRAW, 8'h00);
        write_reg(CFG_WON, 8'h03);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h05);
    endtask

    // Random codes per phase, each phase closed back to idle
    task automatic test_random_traffic();
        random_bytes = 0;
        while (random_bytes < 1200) begin
            randomize_codes($urandom_range(3) == 0);
            repeat ($urandom_range(60, 20)) send_message();
            send_byte(code_marker);
        end
    endtask

    // Stretch with neither side holding off
    task automatic test_back_to_back();
        randomize_codes(1'b0);
        write_reg(CFG_DRAWER, 8'h01);
        quiet = 1'b1;
        repeat (40) send_message();
        send_byte(code_marker);
        quiet = 1'b0;
    endtask

    // Receiver stalls at random
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready = quiet || ($urandom_range(99) >= 13);
        end
    end

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each message transaction with the oldest expectation
    always @(posedge aclk) begin
        msg_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_msgs.size() == 0) begin
                $display("%0t: unexpected message: expected none, actual kind %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_msgs.pop_front();
                check_field("msg_kind", 16'(want.kind), 16'(m_axis_tuser));
                check_field("pos_x", want.x, m_axis_tdata[15:0]);
                check_field("pos_y", want.y, m_axis_tdata[31:16]);
                check_field("pen_down", 16'(want.pen), 16'(m_axis_tdata[32]));
                check_field("value_byte", 16'(want.val), 16'(m_axis_tdata[40:33]));
            end
        end
    end

    initial begin
        int waited;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_MARKER;
        cfg_data       = '0;
        aresetn        = 1'b0;
        quiet          = 1'b0;
        mismatch_count = 0;
        random_bytes   = 0;
        code_marker    = RST_MARKER;
        code_draw      = RST_DRAW;
        code_move      = RST_MOVE;
        code_word      = RST_WORD;
        code_won       = RST_WON;
        btn_first      = RST_FIRST_BTN;
        btn_count      = RST_BTN_COUNT;
        drawer_on      = RST_DRAWER;
        frame_mode     = MODE_IDLE;
        coord_cnt      = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_codes();
        test_overrun_and_buttons();
        test_no_drawer();
        test_code_collisions();
        test_random_traffic();
        test_back_to_back();

        // drain
        waited = 0;
        while (pending_msgs.size() != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (10) @(negedge aclk);
        if (pending_msgs.size() != 0)
            $display("%0t: %0d expected messages never arrived", $time, pending_msgs.size());
        if (mismatch_count == 0 && pending_msgs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
